/* src/integer_to_ascii_radix_top_assert.svh */
// Assertion macros for the integer-to-ASCII converter.
// Used by integer_to_ascii_radix_top; no other dependencies.
`ifndef INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ITAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ITAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/itar_pkg.sv */
// Shared types, constants and character helpers for the integer-to-ASCII converter.
// No dependencies; used by every module of the block.
package itar_pkg;

    localparam int VALUE_W    = 64;
    localparam int FUNC_W     = 2;
    localparam int MINW_W     = 6;
    localparam int LIMIT_W    = 5;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int RADIX_W    = DIGIT_W + 1;
    localparam int MAX_DIGITS = 22;
    localparam int MAX_WIDTH  = 32;
    localparam int RUN_WIDTH_MAX = 32;

    localparam logic [FUNC_W-1:0] FUNC_DEC = 2'd1;

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    typedef enum logic [1:0] {
        RADIX_OCT,
        RADIX_DEC,
        RADIX_HEX
    } t_radix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_SIGN,
        S_PAD,
        S_DIGIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic conv;
        logic shift;
    } t_cell_ctl;

    // The upper selector bit alone picks hexadecimal, so code 3 is hex as well.
    function automatic t_radix itar_decode_radix(input logic [FUNC_W-1:0] func);
        t_radix r;
        if (func[FUNC_W-1]) begin
            r = RADIX_HEX;
        end else if (func == FUNC_DEC) begin
            r = RADIX_DEC;
        end else begin
            r = RADIX_OCT;
        end
        return r;
    endfunction

    function automatic logic [RADIX_W-1:0] itar_radix_value(input t_radix r);
        logic [RADIX_W-1:0] v;
        case (r)
            RADIX_OCT: v = RADIX_W'(8);
            RADIX_DEC: v = RADIX_W'(10);
            RADIX_HEX: v = RADIX_W'(16);
            default:   v = RADIX_W'(16);
        endcase
        return v;
    endfunction

    function automatic logic [CHAR_W-1:0] itar_digit_char(input logic [DIGIT_W-1:0] d,
                                                          input logic upper);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_W'(10)) begin
            c = CHAR_ZERO + CHAR_W'(d);
        end else begin
            c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(d) - CHAR_W'(10);
        end
        return c;
    endfunction

endpackage

/* src/itar_cell.sv */
// One digit cell of the conversion chain: doubles its digit and adds the bit from below.
// Depends on itar_pkg.
module itar_cell (
    input  logic                            i_clk,
    input  itar_pkg::t_cell_ctl             i_ctl,
    input  logic [itar_pkg::RADIX_W-1:0]    i_radix_val,
    input  logic                            i_carry,
    output logic                            o_carry,
    input  logic [itar_pkg::DIGIT_W-1:0]    i_digit,
    output logic [itar_pkg::DIGIT_W-1:0]    o_digit
);
    import itar_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [RADIX_W-1:0] w_sum;
    logic [RADIX_W-1:0] w_diff;
    logic               w_ge;

    // The digit is always below the radix, so twice it plus one stays below twice
    // the radix and a single compare and subtract keeps it in range.
    assign w_sum   = {r_digit, i_carry};
    assign w_ge    = (w_sum >= i_radix_val);
    assign w_diff  = w_sum - i_radix_val;
    assign o_carry = w_ge;
    assign o_digit = r_digit;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = '0;
        end else if (i_ctl.conv) begin
            n_digit = w_ge ? w_diff[DIGIT_W-1:0] : w_sum[DIGIT_W-1:0];
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

/* src/itar_chain.sv */
// Row of digit cells, lowest digit in cell 0; shifts bits in or digits upward.
// Depends on itar_pkg and itar_cell.
module itar_chain #(
    parameter int NUM_CELLS = itar_pkg::MAX_DIGITS
) (
    input  logic                            i_clk,
    input  itar_pkg::t_cell_ctl             i_ctl,
    input  itar_pkg::t_radix                i_radix,
    input  logic                            i_bit,
    output logic [itar_pkg::DIGIT_W-1:0]    o_top_digit,
    output logic                            o_carry_out
);
    import itar_pkg::*;

    logic [RADIX_W-1:0] w_radix_val;
    logic               w_carry    [NUM_CELLS:0];
    logic [DIGIT_W-1:0] w_digit    [NUM_CELLS-1:0];
    logic [DIGIT_W-1:0] w_shift_in [NUM_CELLS-1:0];

    assign w_radix_val = itar_radix_value(i_radix);
    assign w_carry[0]  = i_bit;
    assign w_shift_in[0] = '0;

    genvar k;
    generate
        for (k = 0; k < NUM_CELLS; k++) begin : g_cell
            if (k > 0) begin : g_link
                assign w_shift_in[k] = w_digit[k-1];
            end
            itar_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (i_ctl),
                .i_radix_val (w_radix_val),
                .i_carry     (w_carry[k]),
                .o_carry     (w_carry[k+1]),
                .i_digit     (w_shift_in[k]),
                .o_digit     (w_digit[k])
            );
        end
    endgenerate

    assign o_top_digit = w_digit[NUM_CELLS-1];
    assign o_carry_out = w_carry[NUM_CELLS];

endmodule

/* src/integer_to_ascii_radix_top.sv */
// Channel   | Direction | Handshake                     | Payload
// request   | in        | start high while busy is low  | i_value, i_func, i_min_width,
//           |           |                               | i_pad_zero, i_upper_case, i_digit_limit
// character | out       | o_strobe, high for each char  | o_char_out, o_last
//
// A request is shifted bit-serially through the digit cell chain, then leading zeros
// (and digits above the limit) are shifted out of the top cell, the padding is sized,
// and the characters (at most 33) are emitted in turn. busy stays high through all
// of these steps; each character is registered and appears in the cycle after its
// state. Reset is synchronous and returns the controller to idle.
// The receiver cannot stall, so characters leave at one per cycle.
// Depends on itar_pkg, itar_chain and the assertion macro header.
module integer_to_ascii_radix_top #(
    parameter int MAX_WIDTH = itar_pkg::MAX_WIDTH
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [itar_pkg::VALUE_W-1:0]     i_value,
    input  logic [itar_pkg::FUNC_W-1:0]             i_func,
    input  logic [itar_pkg::MINW_W-1:0]             i_min_width,
    input  logic                                    i_pad_zero,
    input  logic                                    i_upper_case,
    input  logic [itar_pkg::LIMIT_W-1:0]            i_digit_limit,
    output logic                                    o_strobe,
    output logic [itar_pkg::CHAR_W-1:0]             o_char_out,
    output logic                                    o_last
);
    import itar_pkg::*;

    localparam int WIDTH_CAP = (MAX_WIDTH < RUN_WIDTH_MAX) ? MAX_WIDTH : RUN_WIDTH_MAX;
    localparam logic [MINW_W-1:0] WIDTH_CAP_V = MINW_W'(WIDTH_CAP);
    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
    localparam int BCNT_W = $clog2(VALUE_W);

    t_state              r_state, n_state;
    t_radix              r_radix, n_radix;
    logic [VALUE_W-1:0]  r_mag, n_mag;
    logic [BCNT_W-1:0]   r_bit_cnt, n_bit_cnt;
    logic [DCNT_W-1:0]   r_dig_cnt, n_dig_cnt;
    logic [MINW_W-1:0]   r_pad_cnt, n_pad_cnt;
    logic [MINW_W-1:0]   r_width, n_width;
    logic [LIMIT_W-1:0]  r_limit, n_limit;
    logic                r_pad_zero, n_pad_zero;
    logic                r_upper, n_upper;
    logic                r_neg, n_neg;
    logic                r_lead, n_lead;
    logic                r_strobe, n_strobe;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    t_cell_ctl           w_ctl;
    t_radix              w_in_radix;
    logic                w_in_neg;
    logic [DIGIT_W-1:0]  w_top_digit;
    logic                w_carry_top;
    logic                w_accept;
    logic                w_conv_done;
    logic                w_norm_shift;
    logic [MINW_W-1:0]   w_pad_calc;

    itar_chain #(
        .NUM_CELLS (MAX_DIGITS)
    ) u_chain (
        .i_clk       (i_clk),
        .i_ctl       (w_ctl),
        .i_radix     (r_radix),
        .i_bit       (r_mag[VALUE_W-1]),
        .o_top_digit (w_top_digit),
        .o_carry_out (w_carry_top)
    );

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign w_in_radix  = itar_decode_radix(i_func);
    assign w_in_neg    = (w_in_radix != RADIX_HEX) && i_value[VALUE_W-1];
    assign w_conv_done = (r_bit_cnt == BCNT_W'(VALUE_W - 1));

    // Shift while the top cell holds a leading zero (one digit always stays), or
    // while more digits remain than the limit allows. Once a nonzero digit has
    // reached the top, zeros below it are real digits and are kept.
    assign w_norm_shift =
        (r_lead && (r_dig_cnt > DCNT_W'(1)) && (w_top_digit == '0)) ||
        ((r_limit != '0) && (MINW_W'(r_dig_cnt) > MINW_W'(r_limit)));

    assign w_pad_calc = (r_width > MINW_W'(r_dig_cnt)) ? (r_width - MINW_W'(r_dig_cnt)) : '0;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_conv_done) begin
                    n_state = S_NORM;
                end
            end
            S_NORM: begin
                if (!w_norm_shift) begin
                    if (r_neg) begin
                        n_state = S_SIGN;
                    end else if (w_pad_calc != '0) begin
                        n_state = S_PAD;
                    end else begin
                        n_state = S_DIGIT;
                    end
                end
            end
            S_SIGN: begin
                n_state = (r_pad_cnt != '0) ? S_PAD : S_DIGIT;
            end
            S_PAD: begin
                if (r_pad_cnt == MINW_W'(1)) begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (r_dig_cnt == DCNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        n_radix    = r_radix;
        n_mag      = r_mag;
        n_bit_cnt  = r_bit_cnt;
        n_dig_cnt  = r_dig_cnt;
        n_pad_cnt  = r_pad_cnt;
        n_width    = r_width;
        n_limit    = r_limit;
        n_pad_zero = r_pad_zero;
        n_upper    = r_upper;
        n_neg      = r_neg;
        n_lead     = r_lead;
        n_strobe   = 1'b0;
        n_char     = r_char;
        n_last     = 1'b0;
        w_ctl      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_radix    = w_in_radix;
                    n_neg      = w_in_neg;
                    n_mag      = w_in_neg ? (VALUE_W'(0) - $unsigned(i_value))
                                          : $unsigned(i_value);
                    n_bit_cnt  = '0;
                    n_dig_cnt  = DCNT_W'(MAX_DIGITS);
                    n_width    = (i_min_width > WIDTH_CAP_V) ? WIDTH_CAP_V : i_min_width;
                    n_limit    = i_digit_limit;
                    n_pad_zero = i_pad_zero;
                    n_upper    = i_upper_case;
                    n_lead     = 1'b1;
                    w_ctl.clear = 1'b1;
                end
            end
            S_CONV: begin
                w_ctl.conv = 1'b1;
                n_mag      = {r_mag[VALUE_W-2:0], 1'b0};
                n_bit_cnt  = r_bit_cnt + BCNT_W'(1);
            end
            S_NORM: begin
                if (w_top_digit != '0) begin
                    n_lead = 1'b0;
                end
                if (w_norm_shift) begin
                    w_ctl.shift = 1'b1;
                    n_dig_cnt   = r_dig_cnt - DCNT_W'(1);
                end else begin
                    n_pad_cnt = w_pad_calc;
                end
            end
            S_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
            end
            S_PAD: begin
                n_strobe  = 1'b1;
                n_char    = r_pad_zero ? CHAR_ZERO : CHAR_SPACE;
                n_pad_cnt = r_pad_cnt - MINW_W'(1);
            end
            S_DIGIT: begin
                n_strobe    = 1'b1;
                n_char      = itar_digit_char(w_top_digit, r_upper);
                n_last      = (r_dig_cnt == DCNT_W'(1));
                w_ctl.shift = 1'b1;
                n_dig_cnt   = r_dig_cnt - DCNT_W'(1);
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_radix    <= n_radix;
        r_mag      <= n_mag;
        r_bit_cnt  <= n_bit_cnt;
        r_dig_cnt  <= n_dig_cnt;
        r_pad_cnt  <= n_pad_cnt;
        r_width    <= n_width;
        r_limit    <= n_limit;
        r_pad_zero <= n_pad_zero;
        r_upper    <= n_upper;
        r_neg      <= n_neg;
        r_lead     <= n_lead;
        r_char     <= n_char;
    end

    assign o_strobe   = r_strobe;
    assign o_char_out = r_char;
    assign o_last     = r_last;

`include "integer_to_ascii_radix_top_assert.svh"

    `ITAR_ASSERT_IMP(a_last_strobed, i_clk, i_rst_n, o_last, o_strobe, "last without strobe")
    `ITAR_ASSERT_NEXT(a_run_ends, i_clk, i_rst_n, o_last, !o_strobe, "character after last")
    `ITAR_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, r_state == S_CONV, !w_carry_top, "digit chain overflow")
    `ITAR_ASSERT_NEXT(a_accept_quiet, i_clk, i_rst_n, w_accept, busy && !o_strobe, "request not taken")

endmodule
